/* rtl/core/isp_pkg.sv */
// Shared types, character codes and helpers of the infix to postfix converter.
package isp_pkg;

	typedef struct packed {
		logic [7:0] char_in;
		logic       expr_end;
	} in_word_t;

	typedef struct packed {
		logic [7:0] char_out;
		logic       has_char;
		logic       run_last;
		logic       expr_done;
		logic [1:0] error_code;
	} out_word_t;

	// word handed from the control to the output register
	typedef struct packed {
		logic      valid;
		out_word_t word;
	} emit_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHK,
		ST_UNM,
		ST_END,
		ST_FL
	} state_t;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_UNMATCHED = 2'd1;
	localparam logic [1:0] ERR_OVERFLOW  = 2'd2;

	function automatic logic [1:0] prec_of(input logic [7:0] c);
		logic [1:0] p;
		case (c)
			CH_PLUS, CH_MINUS: p = 2'd1;
			CH_STAR, CH_SLASH: p = 2'd2;
			default:           p = 2'd0;
		endcase
		return p;
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c inside {[8'h41:8'h5A], [8'h61:8'h7A]});
	endfunction

	function automatic out_word_t mk_word(input logic [7:0] c, input logic has,
			input logic [1:0] err);
		out_word_t w;
		w.char_out   = c;
		w.has_char   = has;
		w.run_last   = 1'b0;
		w.expr_done  = 1'b0;
		w.error_code = err;
		return w;
	endfunction

endpackage

/* rtl/core/isp_stack_ram.sv */
// Operator stack storage: one write port, one registered read port.
module isp_stack_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/isp_out_stage.sv */
// Output register between the control and the result channel.
module isp_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  isp_pkg::emit_t     to_out,
	output logic               out_free,
	output logic               out_valid,
	input  logic               out_ready,
	output isp_pkg::out_word_t out_data
);

	logic               vld_q;
	isp_pkg::out_word_t word_q;

	assign out_free  = !vld_q || out_ready;
	assign out_valid = vld_q;
	assign out_data  = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (out_free) begin
			vld_q <= to_out.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && to_out.valid) begin
			word_q <= to_out.word;
		end
	end

endmodule

/* rtl/core/isp_ctrl.sv */
// Sequencer: stack pointer, read-modify-write of the stack, one-word result holdback.
module isp_ctrl #(
	parameter int DEPTH = 16,
	localparam int CW   = $clog2(DEPTH + 1),
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  isp_pkg::in_word_t in_data,
	input  logic              out_free,
	output isp_pkg::emit_t    to_out,
	output logic              we,
	output logic [AW-1:0]     waddr,
	output logic [7:0]        wdata,
	output logic [AW-1:0]     raddr,
	input  logic [7:0]        rdata
);

	isp_pkg::state_t    state_q, state_d;
	logic [CW-1:0]      count_q, count_d, count_m1;
	logic [7:0]         c_q;
	logic               end_q;
	logic               close_q;
	isp_pkg::out_word_t pend_q;
	logic               pend_vld_q;

	logic               stall, act;
	logic               emit;
	isp_pkg::out_word_t ew;
	logic               push, pop, fin;
	isp_pkg::out_word_t fin_word;
	logic               popc, full, accept;

	assign accept = in_valid && in_ready;
	assign full   = (count_q >= CW'(DEPTH));
	// operator pass: pop while top is not '(' and binds at least as tight
	assign popc   = close_q || ((rdata != isp_pkg::CH_OPEN) &&
		(isp_pkg::prec_of(rdata) >= isp_pkg::prec_of(c_q)));
	assign act    = !stall;

	// datapath controls
	always_comb begin
		in_ready = 1'b0;
		emit     = 1'b0;
		ew       = '0;
		push     = 1'b0;
		pop      = 1'b0;
		fin      = 1'b0;
		wdata    = c_q;
		fin_word = pend_q;
		case (state_q)
			isp_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				wdata    = in_data.char_in;
				if (in_valid) begin
					if (isp_pkg::is_letter(in_data.char_in)) begin
						emit = 1'b1;
						ew   = isp_pkg::mk_word(in_data.char_in, 1'b1, isp_pkg::ERR_NONE);
					end else if (in_data.char_in == isp_pkg::CH_OPEN) begin
						if (full) begin
							emit = 1'b1;
							ew   = isp_pkg::mk_word(8'h00, 1'b0, isp_pkg::ERR_OVERFLOW);
						end else begin
							push = 1'b1;
						end
					end else if (count_q == '0) begin
						if (in_data.char_in == isp_pkg::CH_CLOSE) begin
							emit = 1'b1;
							ew   = isp_pkg::mk_word(8'h00, 1'b0, isp_pkg::ERR_UNMATCHED);
						end else begin
							push = 1'b1;
						end
					end
				end
			end
			isp_pkg::ST_CHK: begin
				if (close_q) begin
					pop = 1'b1;
					if (rdata != isp_pkg::CH_OPEN) begin
						emit = 1'b1;
						ew   = isp_pkg::mk_word(rdata, 1'b1, isp_pkg::ERR_NONE);
					end
				end else if (popc) begin
					pop  = 1'b1;
					emit = 1'b1;
					ew   = isp_pkg::mk_word(rdata, 1'b1, isp_pkg::ERR_NONE);
					push = (count_q == CW'(1));
				end else if (full) begin
					emit = 1'b1;
					ew   = isp_pkg::mk_word(8'h00, 1'b0, isp_pkg::ERR_OVERFLOW);
				end else begin
					push = 1'b1;
				end
			end
			isp_pkg::ST_UNM: begin
				emit = 1'b1;
				ew   = isp_pkg::mk_word(8'h00, 1'b0, isp_pkg::ERR_UNMATCHED);
			end
			isp_pkg::ST_END: begin
				if (!(end_q && count_q != '0) && (end_q || pend_vld_q)) begin
					fin = 1'b1;
					if (!pend_vld_q) begin
						fin_word = isp_pkg::mk_word(8'h00, 1'b0, isp_pkg::ERR_NONE);
					end
					fin_word.run_last  = 1'b1;
					fin_word.expr_done = end_q;
				end
			end
			isp_pkg::ST_FL: begin
				pop  = 1'b1;
				emit = 1'b1;
				ew   = isp_pkg::mk_word(rdata, 1'b1, isp_pkg::ERR_NONE);
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
		// a held word can only move on when the output register takes it
		stall = !out_free && ((emit && pend_vld_q) || fin);
	end

	// next state
	always_comb begin
		state_d = state_q;
		if (act) begin
			case (state_q)
				isp_pkg::ST_IDLE: begin
					if (accept) begin
						if (isp_pkg::is_letter(in_data.char_in) ||
								in_data.char_in == isp_pkg::CH_OPEN ||
								count_q == '0) begin
							state_d = isp_pkg::ST_END;
						end else begin
							state_d = isp_pkg::ST_CHK;
						end
					end
				end
				isp_pkg::ST_CHK: begin
					if (close_q) begin
						if (rdata == isp_pkg::CH_OPEN) begin
							state_d = isp_pkg::ST_END;
						end else if (count_q == CW'(1)) begin
							state_d = isp_pkg::ST_UNM;
						end
					end else if (!(popc && count_q != CW'(1))) begin
						state_d = isp_pkg::ST_END;
					end
				end
				isp_pkg::ST_UNM: state_d = isp_pkg::ST_END;
				isp_pkg::ST_END: begin
					if (end_q && count_q != '0) begin
						state_d = isp_pkg::ST_FL;
					end else begin
						state_d = isp_pkg::ST_IDLE;
					end
				end
				isp_pkg::ST_FL: begin
					if (count_q == CW'(1)) begin
						state_d = isp_pkg::ST_END;
					end
				end
				default: state_d = isp_pkg::ST_IDLE;
			endcase
		end
	end

	// stack pointer; the read port addresses the top after this cycle (a same-cycle write is not seen)
	always_comb begin
		count_d = count_q;
		if (act) begin
			count_d = count_q + CW'(push) - CW'(pop);
		end
		count_m1 = count_d - CW'(1);
		raddr    = (count_d == '0) ? '0 : count_m1[AW-1:0];
	end

	assign we    = push && act;
	// the write slot is the old top when a pop and push share a cycle
	assign waddr = pop ? count_m1[AW-1:0] : count_q[AW-1:0];

	always_comb begin
		to_out.valid = 1'b0;
		to_out.word  = pend_q;
		if (act && fin) begin
			to_out.valid = 1'b1;
			to_out.word  = fin_word;
		end else if (act && emit && pend_vld_q) begin
			to_out.valid = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= isp_pkg::ST_IDLE;
			count_q    <= '0;
			pend_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (act && fin) begin
				pend_vld_q <= 1'b0;
			end else if (act && emit) begin
				pend_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			c_q     <= in_data.char_in;
			end_q   <= in_data.expr_end;
			close_q <= (in_data.char_in == isp_pkg::CH_CLOSE);
		end
		if (act && emit) begin
			pend_q <= ew;
		end
	end

endmodule

/* rtl/core/infix_to_postfix_converter_top.sv */
// Top level of the infix to postfix converter.
// Converts an infix expression, fed one ASCII character per input word, into
// postfix order with the shunting-yard scheme. Letters pass straight through,
// '(' and operators are kept on a STACK_DEPTH-entry operator stack held in a
// synchronous RAM with a registered read port; the stack pointer lives in a
// register. Each character is handled by a sequencer: a letter, '(' or any
// character arriving on an empty stack goes from ST_IDLE straight to ST_END.
// An operator on a non-empty stack goes to ST_CHK, which pops entries while
// the top binds at least as tight and then pushes the operator before ST_END.
// ')' pops entries in ST_CHK up to and including its matching '('; with no
// matching '(' it empties the stack and passes through ST_UNM for its error
// word. When expr_end is set, ST_FL drains the remaining stack one entry at a
// time before ST_END. Consumer stalls can hold the sequencer. The pace is set
// by the single RAM read port: every pop needs a fresh top-of-stack read.
// Every result word is held back one step so the last word of a character can
// be tagged run_last (and expr_done at the end of an expression); an output
// register lets the next character start while a finished word waits. An
// unmatched ')' or a push onto a full stack yields a word with has_char 0 and
// error_code set. The stack needs no clearing after reset.
module infix_to_postfix_converter_top #(
	parameter int STACK_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  isp_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output isp_pkg::out_word_t out_data
);

	localparam int AW = $clog2(STACK_DEPTH);

	logic           out_free;
	isp_pkg::emit_t to_out;
	logic           we;
	logic [AW-1:0]  waddr, raddr;
	logic [7:0]     wdata, rdata;

	// operator stack storage
	isp_stack_ram #(
		.DEPTH (STACK_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// per-character sequencer and stack pointer
	isp_ctrl #(
		.DEPTH (STACK_DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_free (out_free),
		.to_out   (to_out),
		.we       (we),
		.waddr    (waddr),
		.wdata    (wdata),
		.raddr    (raddr),
		.rdata    (rdata)
	);

	// result word register toward the consumer
	isp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.to_out    (to_out),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
